// ----- rtl/core/vbs_pkg.sv -----
// ----------------------------------------------------------------------------
// vbs_pkg
// Shared types and constants for the vertex blend skinning core.
// ----------------------------------------------------------------------------
`default_nettype none

package vbs_pkg;

	localparam int LANES     = 4;
	localparam int ROWS      = 4;
	localparam int COORD_W   = 32;
	localparam int ROW_W     = 3 * COORD_W;
	localparam int SLOT_W    = 8;
	localparam int WEIGHT_W  = 17;
	localparam int WT_BITS   = 20;
	localparam int ACC_W     = 48;
	localparam int FRAC_BITS = 16;

	localparam logic signed [WT_BITS-1:0] ONE_Q16 = 20'sd65536;

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_SKIN = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		LINKS_ONE   = 3'd1,
		LINKS_TWO   = 3'd2,
		LINKS_THREE = 3'd3,
		LINKS_FOUR  = 3'd4
	} links_t;

	typedef logic signed [COORD_W-1:0] coord_t;

	// palette row write request, broadcast to every lane copy
	typedef struct packed {
		logic              en;
		logic [1:0]        row;
		logic [SLOT_W-1:0] slot;
		logic [ROW_W-1:0]  data;
	} pal_wr_t;

endpackage

`default_nettype wire

// ----- rtl/core/vertex_blend_skinning_core.sv -----
// ----------------------------------------------------------------------------
// vertex_blend_skinning_core
// Linear blend skinning with up to four bones per vertex over a palette
// of affine bone matrices in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   input channel in_valid/in_ready carries load and vertex items. a load
//   (kind 0) writes one three-entry row of palette slot bone_a and gives
//   no result. a vertex (kind 1) gives one skinned position on the
//   output channel out_valid/out_ready.
//   cfg_we/cfg_wdata set the link count (1..4, reset 1); write it only
//   while the block is idle.
//   a vertex result passes stage registers s1 to s4 and then the output
//   register before out_valid rises.
//   throughput: one item per cycle unless the output stalls; each of the
//   four lanes keeps its own palette copy so all bones are read in the
//   same cycle, and 36 plus 12 multipliers work in parallel.
//   a load is visible to a vertex in the very next cycle.
//   when out_ready is low with a result waiting, the whole pipeline holds
//   and in_ready drops; nothing is lost.
//   reset clears the pipeline valid bits and sets the link count to one;
//   the palette holds no defined value until written.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_blend_skinning_core #(
	parameter int PALETTE_BONES = 64,
	parameter int COORD_BITS    = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [1:0]                    row_select,
	input  logic signed [31:0]            coord_x,
	input  logic signed [31:0]            coord_y,
	input  logic signed [31:0]            coord_z,
	input  logic [5:0]                    bone_a,
	input  logic [5:0]                    bone_b,
	input  logic [5:0]                    bone_c,
	input  logic [5:0]                    bone_d,
	input  logic [vbs_pkg::WEIGHT_W-1:0]  weight_a,
	input  logic [vbs_pkg::WEIGHT_W-1:0]  weight_b,
	input  logic [vbs_pkg::WEIGHT_W-1:0]  weight_c,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            skinned_x,
	output logic signed [31:0]            skinned_y,
	output logic signed [31:0]            skinned_z
);
	import vbs_pkg::*;

	localparam int CB = COORD_BITS;

	logic                        adv;
	logic                        acc_in;
	logic [2:0]                  links_q;
	links_t                      links_eff;
	logic signed [WT_BITS-1:0]   wa, wb, wc;
	logic signed [WT_BITS-1:0]   w_in [LANES];
	logic [5:0]                  bone_in [LANES];
	pal_wr_t                     wr;
	coord_t [2:0]                pos;
	logic [2:0][CB-1:0]          t_s3 [LANES];

	logic                        v_s1, v_s2, v_s3, v_s4;
	logic signed [WT_BITS-1:0]   w_s1 [LANES];
	logic signed [WT_BITS-1:0]   w_s2 [LANES];
	logic signed [WT_BITS-1:0]   w_s3 [LANES];
	logic signed [CB+WT_BITS-1:0] wprod [LANES][3];
	logic [ACC_W-1:0]            wp_s4 [LANES][3];
	logic [ACC_W-1:0]            blend [3];

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;
	assign acc_in   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			links_q <= LINKS_ONE;
		else if (cfg_we)
			links_q <= cfg_wdata;
	end

	always_comb begin
		if (links_q < LINKS_ONE)
			links_eff = LINKS_ONE;
		else if (links_q > LINKS_FOUR)
			links_eff = LINKS_FOUR;
		else
			links_eff = links_t'(links_q);
	end

	assign wa = WT_BITS'(weight_a);
	assign wb = WT_BITS'(weight_b);
	assign wc = WT_BITS'(weight_c);

	assign bone_in[0] = bone_a;
	assign bone_in[1] = bone_b;
	assign bone_in[2] = bone_c;
	assign bone_in[3] = bone_d;

	// unused lanes get weight zero, so their transform drops out
	always_comb begin
		for (int l = 0; l < LANES; l++)
			w_in[l] = '0;
		unique case (links_eff)
			LINKS_ONE: begin
				w_in[0] = ONE_Q16;
			end
			LINKS_TWO: begin
				w_in[0] = ONE_Q16 - wa;
				w_in[1] = wa;
			end
			LINKS_THREE: begin
				w_in[0] = wa;
				w_in[1] = wb;
				w_in[2] = ONE_Q16 - wa - wb;
			end
			LINKS_FOUR: begin
				w_in[0] = wa;
				w_in[1] = wb;
				w_in[2] = wc;
				w_in[3] = ONE_Q16 - wa - wb - wc;
			end
			default: begin
				w_in[0] = ONE_Q16;
			end
		endcase
	end

	always_comb begin
		wr.en   = acc_in && (kind == KIND_LOAD) && (int'(bone_a) < PALETTE_BONES);
		wr.row  = row_select;
		wr.slot = SLOT_W'(bone_a);
		wr.data = {coord_z, coord_y, coord_x};
	end

	assign pos[0] = coord_x;
	assign pos[1] = coord_y;
	assign pos[2] = coord_z;

	// unused lanes also force a zero transform, whatever slot they name
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		vbs_lane #(
			.BONES(PALETTE_BONES),
			.CB   (CB)
		) u_lane (
			.clk    (clk),
			.adv    (adv),
			.wr     (wr),
			.rd_slot(SLOT_W'(bone_in[l])),
			.rd_zero((int'(bone_in[l]) >= PALETTE_BONES) || (l >= int'(links_eff))),
			.pos    (pos),
			.t_s3   (t_s3[l])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= acc_in && (kind == KIND_SKIN);
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			out_valid <= v_s4;
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++)
			for (int j = 0; j < 3; j++)
				wprod[l][j] = (CB+WT_BITS)'(signed'(t_s3[l][j])) *
					(CB+WT_BITS)'(w_s3[l]);
		for (int j = 0; j < 3; j++)
			blend[j] = wp_s4[0][j] + wp_s4[1][j] + wp_s4[2][j] + wp_s4[3][j];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1 <= w_in;
			w_s2 <= w_s1;
			w_s3 <= w_s2;
			for (int l = 0; l < LANES; l++)
				for (int j = 0; j < 3; j++)
					wp_s4[l][j] <= ACC_W'(wprod[l][j]);
			skinned_x <= blend[0][ACC_W-1:FRAC_BITS];
			skinned_y <= blend[1][ACC_W-1:FRAC_BITS];
			skinned_z <= blend[2][ACC_W-1:FRAC_BITS];
		end
	end

`ifndef SYNTHESIS
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && kind == KIND_LOAD) |=> !v_s1)
		else $error("load transfer entered the skin pipeline");

	a_skin_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && kind == KIND_SKIN) |=> v_s1)
		else $error("vertex transfer lost at pipeline entry");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable({v_s1, v_s2, v_s3, v_s4}))
		else $error("pipeline moved during output stall");

	a_no_write_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> in_ready)
		else $error("palette written without a transfer");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/vbs_lane.sv -----
// ----------------------------------------------------------------------------
// vbs_lane
// One bone lane: a private copy of the bone palette and the affine
// transform of the vertex position by the bone read from it.
// ----------------------------------------------------------------------------
`default_nettype none

module vbs_lane #(
	parameter int BONES = 64,
	parameter int CB    = 32
) (
	input  logic                         clk,
	input  logic                         adv,
	input  vbs_pkg::pal_wr_t             wr,
	input  logic [vbs_pkg::SLOT_W-1:0]   rd_slot,
	input  logic                         rd_zero,
	input  vbs_pkg::coord_t [2:0]        pos,
	output logic [2:0][CB-1:0]           t_s3
);
	import vbs_pkg::*;

	localparam int BW = (BONES > 1) ? $clog2(BONES) : 1;
	localparam int PW = FRAC_BITS + CB;

	logic [ROW_W-1:0] mem [BONES][ROWS];

	logic [ROW_W-1:0]   rd_s1 [ROWS];
	coord_t [2:0]       pos_s1;
	logic               zero_s1;
	logic [PW-1:0]      prod_s2 [3][3];
	coord_t [2:0]       trans_s2;
	logic               zero_s2;
	logic signed [63:0] full [3][3];
	logic [PW-1:0]      sum3 [3];

	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.slot[BW-1:0]][wr.row] <= wr.data;
		if (adv) begin
			rd_s1   <= mem[rd_slot[BW-1:0]];
			pos_s1  <= pos;
			zero_s1 <= rd_zero;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++)
			for (int j = 0; j < 3; j++)
				full[r][j] = 64'(pos_s1[r]) *
					64'(signed'(rd_s1[r][COORD_W*j +: COORD_W]));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++)
				for (int j = 0; j < 3; j++)
					prod_s2[r][j] <= full[r][j][PW-1:0];
			for (int j = 0; j < 3; j++)
				trans_s2[j] <= rd_s1[3][COORD_W*j +: COORD_W];
			zero_s2 <= zero_s1;
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++)
			sum3[j] = prod_s2[0][j] + prod_s2[1][j] + prod_s2[2][j];
	end

	// floor by 2^16 is the upper slice of the wrapped sum
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++)
				t_s3[j] <= zero_s2 ? '0 : sum3[j][PW-1:FRAC_BITS] + CB'(trans_s2[j]);
		end
	end

endmodule

`default_nettype wire
